// ===== rtl/trilinear_wrap_voxel_sampler_defines.svh =====
// Assertion macros shared by the voxel sampler RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef TRILINEAR_WRAP_VOXEL_SAMPLER_DEFINES_SVH
`define TRILINEAR_WRAP_VOXEL_SAMPLER_DEFINES_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define TWS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tws assertion failed");
// Antecedent implies consequent in the next cycle.
`define TWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tws assertion failed");
`else
`define TWS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TWS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/tws_pkg.sv =====
// Package of the trilinear voxel sampler: sizes, command codes, axis decode.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
package tws_pkg;

  localparam int GRID_SIZE  = 32;
  localparam int VALUE_BITS = 16;
  localparam int FRAC_BITS  = 8;

  // Grid size is a power of two, so repeat wrapping is a bit mask.
  localparam int GRID_BITS   = $clog2(GRID_SIZE);
  localparam int ADDR_W      = 3 * GRID_BITS;
  localparam int CELLS       = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int PER_W       = GRID_BITS + FRAC_BITS;
  localparam int WT_W        = FRAC_BITS + 1;
  localparam int WXY_W       = 2 * FRAC_BITS + 1;
  localparam int PROD_W      = WXY_W + VALUE_BITS;
  localparam int ACC_W       = 3 * FRAC_BITS + VALUE_BITS + 1;
  localparam int NUM_CORNERS = 8;
  localparam int K_W         = 3;

  // Field widths of the channel words.
  localparam int WADDR_W = 15;
  localparam int WVAL_W  = 16;
  localparam int POS_W   = 16;
  localparam int OUT_W   = 16;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic [GRID_BITS-1:0] lo;
    logic [GRID_BITS-1:0] hi;
    logic [FRAC_BITS-1:0] frac;
  } axis_t;

  // Wrap one axis and find the neighbor cells around the position.
  function automatic axis_t axis_decode(input logic [POS_W-1:0] pos);
    logic [PER_W:0] shifted;
    axis_t          a;
    shifted = {1'b0, pos[PER_W-1:0]} + (PER_W + 1)'(1 << (FRAC_BITS - 1));
    a.hi    = shifted[FRAC_BITS +: GRID_BITS];
    a.lo    = a.hi - GRID_BITS'(1);
    a.frac  = shifted[FRAC_BITS-1:0];
    return a;
  endfunction

  // Weight of the upper neighbor is the fraction, of the lower one its complement.
  function automatic logic [WT_W-1:0] axis_weight(input logic [FRAC_BITS-1:0] frac,
                                                  input logic upper);
    logic [WT_W-1:0] w;
    if (upper) begin
      w = {1'b0, frac};
    end else begin
      w = WT_W'(1 << FRAC_BITS) - {1'b0, frac};
    end
    return w;
  endfunction

endpackage

// ===== rtl/tws_if.sv =====
// Valid/ready channel interfaces of the voxel sampler: input word and result word.
// Depends on tws_pkg for the field widths.
`timescale 1ns / 1ps
interface tws_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic        [tws_pkg::WADDR_W-1:0]  write_address;
  logic        [tws_pkg::WVAL_W-1:0]   write_value;
  logic signed [tws_pkg::POS_W-1:0]    pos_x;
  logic signed [tws_pkg::POS_W-1:0]    pos_y;
  logic signed [tws_pkg::POS_W-1:0]    pos_z;

  modport source (output valid, command, write_address, write_value, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, command, write_address, write_value, pos_x, pos_y, pos_z,
                output ready);
endinterface

interface tws_out_if;
  logic                        valid;
  logic                        ready;
  logic [tws_pkg::OUT_W-1:0]   sample_value;

  modport source (output valid, sample_value, input ready);
  modport sink (input valid, sample_value, output ready);
endinterface

// ===== rtl/trilinear_wrap_voxel_sampler.sv =====
// Top level of the trilinear voxel sampler with repeat wrapping.
// Depends on tws_pkg, the channel interfaces in tws_if.sv and the assertion header.
//
// Usage: words arrive on in_chan with valid/ready. A write word (command 0) stores
// write_value at write_address in the voxel memory and gives no result. A sample
// word (command 1) carries a fixed-point position with eight fraction bits per
// axis; each axis wraps modulo the grid size, and one result word with the
// truncated trilinear blend of the eight neighbor voxels leaves on out_chan.
// From acceptance to the result register, the eight voxels are read one per
// cycle through the single port of the voxel memory, and a three-stage
// multiply-accumulate pipe drains after the last read. in_chan is ready only
// while no sample is in work. The result sits in an output register, so the
// next word is accepted while the result waits; if the receiver still stalls
// when the following sample finishes, that sample holds until the register
// frees. Reset (rst_n low, synchronous) clears the control state; the voxel
// memory keeps undefined contents until written.
`timescale 1ns / 1ps
`include "trilinear_wrap_voxel_sampler_defines.svh"
module trilinear_wrap_voxel_sampler (
  input  logic       clk,
  input  logic       rst_n,
  tws_in_if.sink     in_chan,
  tws_out_if.source  out_chan
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [tws_pkg::K_W-1:0]     k_r;
  tws_pkg::axis_t              ax_x_r, ax_y_r, ax_z_r;

  // Voxel memory: single port, registered read data.
  logic [tws_pkg::VALUE_BITS-1:0] mem [tws_pkg::CELLS];
  logic [tws_pkg::VALUE_BITS-1:0] rd_data_r;
  logic [tws_pkg::ADDR_W-1:0]     mem_addr;
  logic [tws_pkg::ADDR_W-1:0]     run_addr;
  logic                           mem_we;
  logic                           addr_ok;

  logic in_acc;
  logic is_sample;
  logic last_k;
  logic pipe_busy;
  logic drain_done;

  // Multiply-accumulate pipe.
  logic                           s1_v_r, s2_v_r, s3_v_r;
  logic [tws_pkg::WT_W-1:0]       wx, wy, wz;
  logic [tws_pkg::WXY_W-1:0]      wxy_r;
  logic [tws_pkg::WT_W-1:0]       wz1_r, wz2_r;
  logic [tws_pkg::PROD_W-1:0]     prod_r;
  logic [tws_pkg::ACC_W-1:0]      term_r;
  logic [tws_pkg::ACC_W-1:0]      acc_r;

  logic                           out_valid_r;
  logic [tws_pkg::OUT_W-1:0]      out_data_r;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign is_sample     = in_acc && (in_chan.command == tws_pkg::CMD_SAMPLE);
  assign addr_ok       = {17'd0, in_chan.write_address} < 32'(tws_pkg::CELLS);
  assign mem_we        = in_acc && (in_chan.command == tws_pkg::CMD_WRITE) && addr_ok;

  // Corner k selects upper or lower neighbor per axis: bit 0 for x, 1 for y, 2 for z.
  assign run_addr = {(k_r[2] ? ax_z_r.hi : ax_z_r.lo),
                     (k_r[1] ? ax_y_r.hi : ax_y_r.lo),
                     (k_r[0] ? ax_x_r.hi : ax_x_r.lo)};
  assign mem_addr = mem_we ? in_chan.write_address[tws_pkg::ADDR_W-1:0] : run_addr;

  assign wx = tws_pkg::axis_weight(ax_x_r.frac, k_r[0]);
  assign wy = tws_pkg::axis_weight(ax_y_r.frac, k_r[1]);
  assign wz = tws_pkg::axis_weight(ax_z_r.frac, k_r[2]);

  assign last_k     = (k_r == tws_pkg::K_W'(tws_pkg::NUM_CORNERS - 1));
  assign pipe_busy  = s1_v_r || s2_v_r || s3_v_r;
  assign drain_done = (state_r == ST_DRAIN) && !pipe_busy && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (is_sample) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_k) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= (state_r == ST_RUN) ? k_r + tws_pkg::K_W'(1) : '0;
      s1_v_r  <= (state_r == ST_RUN);
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      if (drain_done) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Voxel memory port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= in_chan.write_value[tws_pkg::VALUE_BITS-1:0];
    end
    rd_data_r <= mem[mem_addr];
  end

  // Datapath: axis decode at acceptance, then weight, voxel product, z weight, sum.
  always_ff @(posedge clk) begin
    if (is_sample) begin
      ax_x_r <= tws_pkg::axis_decode(in_chan.pos_x);
      ax_y_r <= tws_pkg::axis_decode(in_chan.pos_y);
      ax_z_r <= tws_pkg::axis_decode(in_chan.pos_z);
    end
    wxy_r  <= tws_pkg::WXY_W'(wx * wy);
    wz1_r  <= wz;
    prod_r <= tws_pkg::PROD_W'(wxy_r * rd_data_r);
    wz2_r  <= wz1_r;
    term_r <= tws_pkg::ACC_W'(prod_r * wz2_r);
    if (is_sample) begin
      acc_r <= '0;
    end else if (s3_v_r) begin
      acc_r <= acc_r + term_r;
    end
    if (drain_done) begin
      out_data_r <= acc_r[3 * tws_pkg::FRAC_BITS +: tws_pkg::OUT_W];
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.sample_value = out_data_r;

  `TWS_ASSERT_IMPL(a_no_write_busy, clk, rst_n, state_r != ST_IDLE, !mem_we)
  `TWS_ASSERT_NEXT(a_run_feeds_pipe, clk, rst_n, state_r == ST_RUN, s1_v_r)
  `TWS_ASSERT_IMPL(a_acc_in_sample, clk, rst_n, s3_v_r, state_r == ST_RUN || state_r == ST_DRAIN)
  `TWS_ASSERT_IMPL(a_out_from_drain, clk, rst_n, $rose(out_valid_r), $past(state_r == ST_DRAIN))

endmodule

// ===== bench/tws_blend_checker.sv =====
// Checker of the voxel sampler. It keeps a copy of the voxel memory built from
// accepted write words, predicts each sample's blend and compares the result words in order.
// Depends on tws_pkg and the channel interfaces in tws_if.sv.
`timescale 1ns / 1ps
module tws_blend_checker (
  input  logic clk,
  input  logic rst_n,
  tws_in_if    in_mon,
  tws_out_if   out_mon,
  output int   fail_count,
  output int   pending
);

  logic [tws_pkg::VALUE_BITS-1:0] voxel_mirror [tws_pkg::CELLS];
  logic [tws_pkg::OUT_W-1:0]      blend_q [$];
  int                             errors;

  // Repeat-wrap one axis and find the neighbor cells around the position.
  // Cell i is centered at i + 1/2, so the position is shifted by half a cell first.
  function automatic void wrap_axis(input logic signed [tws_pkg::POS_W-1:0] pos,
                                    output int lower, output int upper,
                                    output int unsigned frac);
    int period;
    int q;
    int centered;
    period = tws_pkg::GRID_SIZE << tws_pkg::FRAC_BITS;
    q = int'(pos) % period;
    if (q < 0) begin
      q = q + period;
    end
    centered = q + (1 << (tws_pkg::FRAC_BITS - 1));
    upper = (centered >> tws_pkg::FRAC_BITS) % tws_pkg::GRID_SIZE;
    lower = (upper + tws_pkg::GRID_SIZE - 1) % tws_pkg::GRID_SIZE;
    frac = centered & ((1 << tws_pkg::FRAC_BITS) - 1);
  endfunction

  // Exact trilinear blend of the eight neighbors, truncated to an integer.
  function automatic logic [tws_pkg::OUT_W-1:0] predict_blend(
      input logic signed [tws_pkg::POS_W-1:0] px,
      input logic signed [tws_pkg::POS_W-1:0] py,
      input logic signed [tws_pkg::POS_W-1:0] pz);
    int              xc [2];
    int              yc [2];
    int              zc [2];
    int unsigned     fx, fy, fz;
    longint unsigned wx [2];
    longint unsigned wy [2];
    longint unsigned wz [2];
    longint unsigned acc;
    int              i, j, k;
    wrap_axis(px, xc[0], xc[1], fx);
    wrap_axis(py, yc[0], yc[1], fy);
    wrap_axis(pz, zc[0], zc[1], fz);
    wx[0] = (1 << tws_pkg::FRAC_BITS) - fx;
    wx[1] = fx;
    wy[0] = (1 << tws_pkg::FRAC_BITS) - fy;
    wy[1] = fy;
    wz[0] = (1 << tws_pkg::FRAC_BITS) - fz;
    wz[1] = fz;
    acc = 0;
    for (k = 0; k < 2; k++) begin
      for (j = 0; j < 2; j++) begin
        for (i = 0; i < 2; i++) begin
          acc = acc + wx[i] * wy[j] * wz[k] *
                longint'(voxel_mirror[(zc[k] * tws_pkg::GRID_SIZE + yc[j]) *
                                      tws_pkg::GRID_SIZE + xc[i]]);
        end
      end
    end
    return tws_pkg::OUT_W'(acc >> (3 * tws_pkg::FRAC_BITS));
  endfunction

  // Outputs are checked before inputs so that a sample accepted in the same cycle
  // never lines up against a result word of an older sample.
  always @(posedge clk) begin
    logic [tws_pkg::OUT_W-1:0] want;
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        if (blend_q.size() == 0) begin
          if (errors < 10) begin
            $display("result word %0d arrived with no sample outstanding",
                     out_mon.sample_value);
          end
          errors++;
        end else begin
          want = blend_q.pop_front();
          if (out_mon.sample_value !== want) begin
            if (errors < 10) begin
              $display("sample_value mismatch: expected %0d, got %0d", want,
                       out_mon.sample_value);
            end
            errors++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.command == tws_pkg::CMD_WRITE) begin
          voxel_mirror[in_mon.write_address] = in_mon.write_value[tws_pkg::VALUE_BITS-1:0];
        end else begin
          blend_q.push_back(predict_blend(in_mon.pos_x, in_mon.pos_y, in_mon.pos_z));
        end
      end
      fail_count <= errors;
      pending    <= blend_q.size();
    end
  end

endmodule

// ===== bench/tb_trilinear_wrap_voxel_sampler.sv =====
// Top of the voxel sampler testbench: clock, reset, input and result stimulus, watchdog, verdict.
// Depends on tws_pkg, tws_if.sv, the sampler RTL and the checker in tws_blend_checker.sv.
`timescale 1ns / 1ps
module tb_trilinear_wrap_voxel_sampler;

  // Number of random words after the fill and the directed part.
  localparam int RANDOM_WORDS    = 760;
  // The receiver holds off this long once, so that the output register fills,
  // a second sample waits on it and the input channel stalls.
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 24;
  // Cycles with no word moving on either channel before the run is declared hung.
  // The longest correct quiet stretch falls in the receiver's hold-off.
  localparam int WATCHDOG_LIMIT  = 2000;
  // Only a window of LIVE_CELLS cells per axis, from cell LIVE_BASE on and wrapping
  // through cell 0, is written before sampling; every sample's neighbors fall inside it.
  localparam int LIVE_BASE       = tws_pkg::GRID_SIZE - 2;
  localparam int LIVE_CELLS      = 6;

  logic clk;
  logic rst_n;

  tws_in_if  in_chan ();
  tws_out_if out_chan ();

  int fail_count;
  int pending;

  // Both sides stop idling while this is set. It is written with nonblocking
  // assignments so that the receiver never races the stimulus on it.
  logic steady;
  // Each increment asks the receiver for one long hold-off.
  int   hold_requests;

  trilinear_wrap_voxel_sampler dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  tws_blend_checker u_blend_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Idle length for either side: mostly none or short, now and then a long one.
  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) begin
      return 0;
    end
    if (r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Voxel values lean on both extremes so that the blend reaches 0 and full scale.
  function automatic logic [tws_pkg::WVAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return '1;
    end
    return tws_pkg::WVAL_W'($urandom);
  endfunction

  // Linear address of a cell of the written window, given its offsets in the window.
  function automatic logic [tws_pkg::WADDR_W-1:0] live_address(input int ix, input int iy,
                                                               input int iz);
    int cx;
    int cy;
    int cz;
    cx = (LIVE_BASE + ix) % tws_pkg::GRID_SIZE;
    cy = (LIVE_BASE + iy) % tws_pkg::GRID_SIZE;
    cz = (LIVE_BASE + iz) % tws_pkg::GRID_SIZE;
    return tws_pkg::WADDR_W'((cz * tws_pkg::GRID_SIZE + cy) * tws_pkg::GRID_SIZE + cx);
  endfunction

  // Writes mostly refresh the window, some land anywhere in the grid.
  function automatic logic [tws_pkg::WADDR_W-1:0] pick_address();
    if ($urandom_range(0, 3) == 0) begin
      return tws_pkg::WADDR_W'($urandom);
    end
    return live_address($urandom_range(0, LIVE_CELLS - 1), $urandom_range(0, LIVE_CELLS - 1),
                        $urandom_range(0, LIVE_CELLS - 1));
  endfunction

  // Positions keep the upper neighbor inside the window, one cell above its base, so
  // both neighbors are written. A random number of whole periods spreads them over the
  // 16-bit range, negative values included. Some sit close to a cell center (where the
  // neighbor pair changes), some at the edges of the field and of the grid.
  function automatic logic [tws_pkg::POS_W-1:0] pick_position();
    int r;
    int upper_cell;
    int frac;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      upper_cell = (LIVE_BASE + 1 + $urandom_range(0, LIVE_CELLS - 2)) % tws_pkg::GRID_SIZE;
      if (r < 20) begin
        frac = ($urandom_range(0, 4) + (1 << tws_pkg::FRAC_BITS) - 2) %
               (1 << tws_pkg::FRAC_BITS);
      end else begin
        frac = $urandom_range(0, (1 << tws_pkg::FRAC_BITS) - 1);
      end
      return tws_pkg::POS_W'((upper_cell << tws_pkg::FRAC_BITS) -
                             (1 << (tws_pkg::FRAC_BITS - 1)) + frac +
                             (tws_pkg::GRID_SIZE << tws_pkg::FRAC_BITS) *
                             $urandom_range(0, 7));
    end
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sd0;
      3: return -16'sd1;
      4: return 16'sd128;
      5: return 16'sd127;
      6: return 16'sd8064;
      default: return 16'sd8063;
    endcase
  endfunction

  // Offer one word after an optional gap and wait until it is accepted. Valid is
  // left high afterwards, so the next word can follow in the very next cycle.
  task automatic send_word(input logic cmd, input logic [tws_pkg::WADDR_W-1:0] addr,
                           input logic [tws_pkg::WVAL_W-1:0] val,
                           input logic [tws_pkg::POS_W-1:0] px,
                           input logic [tws_pkg::POS_W-1:0] py,
                           input logic [tws_pkg::POS_W-1:0] pz,
                           input int gap);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.command       <= cmd;
    in_chan.write_address <= addr;
    in_chan.write_value   <= val;
    in_chan.pos_x         <= px;
    in_chan.pos_y         <= py;
    in_chan.pos_z         <= pz;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // The fields a command does not use carry random junk.
  task automatic write_voxel(input logic [tws_pkg::WADDR_W-1:0] addr,
                             input logic [tws_pkg::WVAL_W-1:0] val, input int gap);
    send_word(tws_pkg::CMD_WRITE, addr, val, tws_pkg::POS_W'($urandom),
              tws_pkg::POS_W'($urandom), tws_pkg::POS_W'($urandom), gap);
  endtask

  task automatic sample_at(input logic [tws_pkg::POS_W-1:0] px,
                           input logic [tws_pkg::POS_W-1:0] py,
                           input logic [tws_pkg::POS_W-1:0] pz, input int gap);
    send_word(tws_pkg::CMD_SAMPLE, tws_pkg::WADDR_W'($urandom), tws_pkg::WVAL_W'($urandom),
              px, py, pz, gap);
  endtask

  // Lower valid and wait until every sample sent so far has returned its result.
  // The extra edge lets the checker count a sample accepted in the current cycle.
  task automatic wait_results_drained();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Result side: ready is high most cycles, with random gaps, and once it goes
  // low for a long stretch when the stimulus asks for it.
  initial begin : receiver
    int gap;
    int served;
    served = 0;
    out_chan.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_requests != served) begin
        served++;
        out_chan.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        gap = next_gap();
        if (gap > 0) begin
          out_chan.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Ends the run if nothing moves on either channel for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("FAIL trilinear_wrap_voxel_sampler");
    $finish;
  end

  initial begin : stimulus
    int   n;
    int   ix;
    int   iy;
    int   iz;
    logic hold_window;
    // Every input of the block is known from time zero.
    rst_n                 = 1'b0;
    steady                = 1'b0;
    hold_requests         = 0;
    in_chan.valid         = 1'b0;
    in_chan.command       = tws_pkg::CMD_WRITE;
    in_chan.write_address = '0;
    in_chan.write_value   = '0;
    in_chan.pos_x         = '0;
    in_chan.pos_y         = '0;
    in_chan.pos_z         = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The voxel memory is undefined until written, so the whole window is filled
    // before the first sample. Gaps are rare here to keep the fill short.
    for (iz = 0; iz < LIVE_CELLS; iz++) begin
      for (iy = 0; iy < LIVE_CELLS; iy++) begin
        for (ix = 0; ix < LIVE_CELLS; ix++) begin
          write_voxel(live_address(ix, iy, iz), pick_value(),
                      ($urandom_range(0, 7) == 0) ? next_gap() : 0);
        end
      end
    end

    // Directed words. Full scale exactly on the center of cell 0, where all weight
    // sits on one voxel.
    write_voxel(15'd0, 16'hFFFF, 0);
    sample_at(16'sd128, 16'sd128, 16'sd128, 0);
    // Zero on the center of the last cell; the upper neighbor wraps to cell 0
    // with no weight, and the negative position wraps onto the same point.
    write_voxel(15'h7FFF, 16'h0000, 0);
    sample_at(16'sd8064, 16'sd8064, 16'sd8064, 0);
    sample_at(-16'sd128, -16'sd128, -16'sd128, 0);
    // Below the center of cell 0 the lower neighbor is the last cell.
    write_voxel(15'h7FFF, 16'hFFFF, 0);
    sample_at(16'sh8000, 16'sh8000, 16'sh8000, 0);
    sample_at(16'sd0, 16'sd0, 16'sd0, 2);
    // Largest positive position, and the largest fraction on each axis.
    sample_at(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
    sample_at(16'sd8063, 16'sd8063, 16'sd8063, 0);
    sample_at(16'sd0, -16'sd1, 16'sd8063, 0);
    // Mixed neighbors with a strong contrast between them.
    write_voxel(15'd1, 16'h0000, 0);
    write_voxel(15'd32, 16'hFFFF, 0);
    write_voxel(15'd1024, 16'h0000, 0);
    sample_at(16'sd127, 16'sd255, 16'sd383, 0);
    sample_at(16'sd200, 16'sd129, 16'sd300, 0);
    sample_at(16'sh7FFF, 16'sh8000, 16'sd128, 0);

    // Random part: roughly four writes to six samples. Items 250 to 349 run with
    // no idling on either side. From item 500 the receiver holds off while the
    // sender keeps offering samples back to back. At item 700 the sender waits
    // until every result has come back.
    for (n = 0; n < RANDOM_WORDS; n++) begin
      hold_window = (n >= 500 && n < 530);
      steady <= (n >= 250 && n < 350) || hold_window;
      if (n == 500) begin
        hold_requests <= hold_requests + 1;
      end
      if (n == 700) begin
        wait_results_drained();
      end
      if (!hold_window && $urandom_range(0, 9) < 4) begin
        write_voxel(pick_address(), pick_value(), next_gap());
      end else begin
        sample_at(pick_position(), pick_position(), pick_position(), next_gap());
      end
    end

    // Let the last results come back, then give the block time to show any
    // stray word before the verdict.
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS trilinear_wrap_voxel_sampler");
    end else begin
      $display("FAIL trilinear_wrap_voxel_sampler");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tws_pkg.sv
rtl/tws_if.sv
rtl/trilinear_wrap_voxel_sampler.sv
bench/tws_blend_checker.sv
bench/tb_trilinear_wrap_voxel_sampler.sv
